@@ src/sha1md_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sha1md_pkg;

  typedef logic [31:0]      word_t;
  typedef word_t [4:0]      hash_t;
  typedef word_t [15:0]     sched_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  // datapath controls from the sequencer
  typedef struct packed {
    logic       put;
    logic [1:0] put_pos;
    logic [7:0] put_byte;
    logic       load_work;
    logic       round_en;
    logic       expand;
    logic       fold;
    logic       load_iv;
  } sha1md_ctl_t;

  // digest word hand-off to the output register
  typedef struct packed {
    logic       emit;
    logic [2:0] idx;
  } sha1md_emit_t;

  localparam word_t IV0 = 32'h67452301;
  localparam word_t IV1 = 32'hEFCDAB89;
  localparam word_t IV2 = 32'h98BADCFE;
  localparam word_t IV3 = 32'h10325476;
  localparam word_t IV4 = 32'hC3D2E1F0;

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK    = 8'h80;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam logic [5:0] BLOCK_LAST  = 6'd63;
  localparam logic [6:0] RND_PHASE1  = 7'd20;
  localparam logic [6:0] RND_PHASE2  = 7'd40;
  localparam logic [6:0] RND_PHASE3  = 7'd60;
  localparam logic [6:0] RND_EXPAND  = 7'd16;
  localparam logic [6:0] RND_LAST    = 7'd79;
  localparam logic [2:0] WORD_LAST   = 3'd4;
  localparam logic [2:0] LEN_BYTE_LAST = 3'd7;

  localparam hash_t IV = {IV4, IV3, IV2, IV1, IV0};

  // round function selected by round phase
  function automatic word_t round_f(logic [6:0] rnd, word_t b, word_t c, word_t d);
    word_t f;
    priority if (rnd < RND_PHASE1) begin
      f = (b & c) | (~b & d);
    end else if (rnd < RND_PHASE2 || rnd >= RND_PHASE3) begin
      f = b ^ c ^ d;
    end else begin
      f = (b & c) | (b & d) | (c & d);
    end
    return f;
  endfunction

  // round constant selected by round phase
  function automatic word_t round_k(logic [6:0] rnd);
    word_t k;
    priority if (rnd < RND_PHASE1) begin
      k = K0;
    end else if (rnd < RND_PHASE2) begin
      k = K1;
    end else if (rnd < RND_PHASE3) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

@@ src/sha1md_sched.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sha1md_sched (
  input  wire                      clk,
  input  sha1md_pkg::sha1md_ctl_t  ctl,
  output sha1md_pkg::word_t        w
);
  import sha1md_pkg::*;

  sched_t      q_r;
  logic [23:0] acc_r;
  word_t       mix;
  word_t       packed_word;

  // expanded schedule word from the fixed taps
  assign mix         = q_r[13] ^ q_r[8] ^ q_r[2] ^ q_r[0];
  assign w           = ctl.expand ? {mix[30:0], mix[31]} : q_r[0];
  assign packed_word = {acc_r, ctl.put_byte};

  // byte packing and 16-word shift line
  always_ff @(posedge clk) begin
    if (ctl.put) begin
      acc_r <= {acc_r[15:0], ctl.put_byte};
      if (ctl.put_pos == 2'd3) begin
        q_r <= {packed_word, q_r[15:1]};
      end
    end else if (ctl.round_en) begin
      q_r <= {w, q_r[15:1]};
    end
  end

endmodule

`default_nettype wire

@@ src/sha1md_round.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sha1md_round (
  input  wire                      clk,
  input  wire                      rst_n,
  input  sha1md_pkg::sha1md_ctl_t  ctl,
  input  wire [6:0]                rnd,
  input  sha1md_pkg::word_t        w,
  output sha1md_pkg::hash_t        chain
);
  import sha1md_pkg::*;

  hash_t work_r;
  hash_t chain_r;
  word_t t;

  assign chain = chain_r;

  // shared round adder
  assign t = {work_r[0][26:0], work_r[0][31:27]}
           + round_f(rnd, work_r[1], work_r[2], work_r[3])
           + work_r[4] + round_k(rnd) + w;

  // working variables a..e
  always_ff @(posedge clk) begin
    if (ctl.load_work) begin
      work_r <= chain_r;
    end else if (ctl.round_en) begin
      work_r[4] <= work_r[3];
      work_r[3] <= work_r[2];
      work_r[2] <= {work_r[1][1:0], work_r[1][31:2]};
      work_r[1] <= work_r[0];
      work_r[0] <= t;
    end
  end

  // chaining hash
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= IV;
    end else if (ctl.load_iv) begin
      chain_r <= IV;
    end else if (ctl.fold) begin
      for (int i = 0; i < 5; i++) begin
        chain_r[i] <= chain_r[i] + work_r[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ src/sha1md_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sha1md_ctrl (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire [7:0]                 in_msg_byte,
  input  wire                       in_byte_present,
  input  wire                       in_last,
  input  wire                       out_load_ok,
  output sha1md_pkg::sha1md_ctl_t   ctl,
  output logic [6:0]                rnd,
  output sha1md_pkg::sha1md_emit_t  emit
);
  import sha1md_pkg::*;

  state_t      state_r, state_nxt;
  logic [5:0]  cnt_r;
  logic [63:0] len_r;
  logic [6:0]  rnd_r;
  logic        fin_r;
  logic        mark_r;
  logic        lenact_r;
  logic [2:0]  lcnt_r;
  logic        done_r;
  logic [2:0]  oidx_r;

  logic        in_xfer;
  logic        full;
  logic        len_byte;
  logic        out_done;

  assign rnd = rnd_r;

  // control outputs
  always_comb begin
    in_stall      = (state_r != ST_IDLE);
    in_xfer       = in_valid && (state_r == ST_IDLE);
    ctl           = '0;
    ctl.put_pos   = cnt_r[1:0];
    len_byte      = 1'b0;
    emit.emit     = 1'b0;
    emit.idx      = oidx_r;
    unique case (state_r)
      ST_IDLE: begin
        ctl.put      = in_xfer && in_byte_present;
        ctl.put_byte = in_msg_byte;
      end
      ST_PAD: begin
        ctl.put = 1'b1;
        if (!mark_r) begin
          ctl.put_byte = PAD_MARK;
        end else if (!lenact_r && cnt_r != LEN_POS) begin
          ctl.put_byte = 8'd0;
        end else begin
          ctl.put_byte = len_r[63:56];
          len_byte     = 1'b1;
        end
      end
      ST_ROUND: begin
        ctl.round_en = 1'b1;
        ctl.expand   = (rnd_r >= RND_EXPAND);
      end
      ST_FOLD: begin
        ctl.fold = 1'b1;
      end
      ST_OUT: begin
        emit.emit = out_load_ok;
      end
      default: begin
      end
    endcase
    full          = ctl.put && (cnt_r == BLOCK_LAST);
    ctl.load_work = full;
    out_done      = emit.emit && (oidx_r == WORD_LAST);
    ctl.load_iv   = out_done;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (full) begin
            state_nxt = ST_ROUND;
          end else if (in_last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (full) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd_r == RND_LAST) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        priority if (fin_r && done_r) begin
          state_nxt = ST_OUT;
        end else if (fin_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      len_r    <= '0;
      rnd_r    <= '0;
      fin_r    <= 1'b0;
      mark_r   <= 1'b0;
      lenact_r <= 1'b0;
      lcnt_r   <= '0;
      done_r   <= 1'b0;
      oidx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (ctl.put) begin
        cnt_r <= cnt_r + 6'd1;
      end
      if (ctl.round_en) begin
        rnd_r <= (rnd_r == RND_LAST) ? 7'd0 : rnd_r + 7'd1;
      end
      if (in_xfer && in_last) begin
        fin_r <= 1'b1;
      end
      if (state_r == ST_PAD) begin
        mark_r <= 1'b1;
      end
      // length count, shifted out as the padding tail
      if (out_done) begin
        len_r <= '0;
      end else if (len_byte) begin
        len_r <= {len_r[55:0], 8'd0};
      end else if (in_xfer && in_byte_present) begin
        len_r <= len_r + 64'd8;
      end
      if (len_byte) begin
        lenact_r <= 1'b1;
        lcnt_r   <= lcnt_r + 3'd1;
        if (lcnt_r == LEN_BYTE_LAST) begin
          done_r <= 1'b1;
        end
      end
      if (emit.emit && !out_done) begin
        oidx_r <= oidx_r + 3'd1;
      end
      if (out_done) begin
        fin_r    <= 1'b0;
        mark_r   <= 1'b0;
        lenact_r <= 1'b0;
        lcnt_r   <= '0;
        done_r   <= 1'b0;
        oidx_r   <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_rnd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_ROUND |-> rnd_r == 7'd0)
    else $error("round counter not zero outside rounds");

  a_out_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT |-> cnt_r == 6'd0 && done_r && fin_r)
    else $error("digest output before padding finished");

  a_pad_open: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PAD |-> !done_r && fin_r)
    else $error("padding after length written");

  a_msg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_done |=> len_r == 64'd0 && cnt_r == 6'd0 && !fin_r)
    else $error("message state not cleared after digest");
`endif

endmodule

`default_nettype wire

@@ src/sha1_message_digest.sv @@
`timescale 1ns / 1ps
`default_nettype none

// absorb: one byte per cycle while in_stall is low; the 64th byte of each
//   block starts 80 rounds on the shared round adder, then one fold
// final item: 9 to 72 padding bytes, one or two compressions, then
//   five digest words, one per cycle when out_stall is low
// after the last fold the sequencer enters ST_OUT, which loads the first digest word into the output register
// synchronous active-low reset loads the initial vector and clears all counts
module sha1_message_digest (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_msg_byte,
  input  wire         in_byte_present,
  input  wire         in_last,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha1md_pkg::*;

  sha1md_ctl_t  ctl;
  sha1md_emit_t emit;
  logic [6:0]   rnd;
  word_t        w;
  hash_t        chain;
  word_t        sel_word;
  logic         out_load_ok;

  logic         out_valid_r;
  word_t        out_word_r;
  logic [2:0]   out_idx_r;
  logic         out_last_r;

  assign out_load_ok     = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = out_last_r;

  sha1md_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_msg_byte     (in_msg_byte),
    .in_byte_present (in_byte_present),
    .in_last         (in_last),
    .out_load_ok     (out_load_ok),
    .ctl             (ctl),
    .rnd             (rnd),
    .emit            (emit)
  );

  sha1md_sched u_sched (
    .clk (clk),
    .ctl (ctl),
    .w   (w)
  );

  sha1md_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .rnd   (rnd),
    .w     (w),
    .chain (chain)
  );

  // digest word select
  always_comb begin
    unique case (emit.idx)
      3'd0:    sel_word = chain[0];
      3'd1:    sel_word = chain[1];
      3'd2:    sel_word = chain[2];
      3'd3:    sel_word = chain[3];
      default: sel_word = chain[4];
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.emit) begin
      out_word_r <= sel_word;
      out_idx_r  <= emit.idx;
      out_last_r <= (emit.idx == WORD_LAST);
    end
  end

endmodule

`default_nettype wire
